### design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared widths, register indexes and handoff types of the current meter.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int PEAK_W     = 19;
    localparam int GAIN_W     = 16;
    localparam int WIN_W      = 16;
    localparam int OUT_W      = 16;
    localparam int PROD_W     = PEAK_W + GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_SUM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16       = 3'd3;

    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd5000;
    localparam logic [PEAK_W-1:0] DEADBAND_RESET = 19'd1228;
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd8214;
    localparam int                ZERO_RESET     = 1920;

    localparam logic [PEAK_W-1:0] PEAK_MAX = 19'h7FFFF;
    localparam logic [OUT_W-1:0]  OUT_MAX  = 16'hFFFF;
    localparam logic [PROD_W:0]   ROUND_HALF = 36'd32768;

    // ring fill status seen by the control logic
    typedef struct packed {
        logic filled;     // last cell holds a written sample
        logic fill_next;  // last cell holds one after the next shift
    } csp_fill_t;

    // finished window peak handed to the scaler
    typedef struct packed {
        logic              valid;
        logic [PEAK_W-1:0] peak;
    } csp_tok_t;

    // scaler settings
    typedef struct packed {
        logic [PEAK_W-1:0] deadband;
        logic [GAIN_W-1:0] gain;
    } csp_scale_cfg_t;

endpackage

### design/csp_cell.sv
// ----------------------------------------------------------------------------
// csp_cell
// One tap of the averaging line: holds a deviation and its written flag.
// ----------------------------------------------------------------------------
module csp_cell
    import csp_pkg::*;
#(
    parameter int W = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] d_in,
    input  logic         v_in,
    output logic [W-1:0] d_out,
    output logic         v_out
);

    logic [W-1:0] data_reg;
    logic         valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            data_reg  <= d_in;
            valid_reg <= v_in;
        end
    end

    assign d_out = data_reg;
    assign v_out = valid_reg;

endmodule

### design/csp_chain.sv
// ----------------------------------------------------------------------------
// csp_chain
// Row of averaging cells; the last cell gives the sample leaving the window.
// ----------------------------------------------------------------------------
module csp_chain
    import csp_pkg::*;
#(
    parameter int DEPTH = 100,
    parameter int W     = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] din,
    output logic [W-1:0] oldest,
    output csp_fill_t    fill
);

    logic [W-1:0] d [DEPTH];
    logic         v [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                csp_cell #(.W(W)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d_in  (din),
                    .v_in  (1'b1),
                    .d_out (d[i]),
                    .v_out (v[i])
                );
            end
            else
            begin : g_body
                csp_cell #(.W(W)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d_in  (d[i-1]),
                    .v_in  (v[i-1]),
                    .d_out (d[i]),
                    .v_out (v[i])
                );
            end
        end
    endgenerate

    assign oldest         = d[DEPTH-1];
    assign fill.filled    = v[DEPTH-1];
    assign fill.fill_next = v[DEPTH-2];

endmodule

### design/csp_scale.sv
// ----------------------------------------------------------------------------
// csp_scale
// Peak to milliamps: gain multiply, deadband, round half up, saturate.
// ----------------------------------------------------------------------------
module csp_scale
    import csp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  csp_scale_cfg_t    cfg,
    input  csp_tok_t          tok,
    output logic              tok_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  current_ma
);

    logic              pk_valid_reg;
    logic [PEAK_W-1:0] pk_reg;
    logic              prod_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              dead_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  cur_reg;

    logic              out_free;
    logic              prod_move;
    logic              pk_move;
    logic [PROD_W:0]   rounded;
    logic [OUT_W-1:0]  cur_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign prod_move = prod_valid_reg && out_free;
    assign pk_move   = pk_valid_reg && (!prod_valid_reg || prod_move);
    assign tok_ready = !pk_valid_reg || pk_move;

    always_comb
    begin
        rounded = {1'b0, prod_reg} + ROUND_HALF;
        if (dead_reg)
            cur_next = '0;
        else if (|rounded[PROD_W:OUT_W+16])
            cur_next = OUT_MAX;
        else
            cur_next = rounded[OUT_W+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tok_ready)
                pk_valid_reg <= tok.valid;
            if (!prod_valid_reg || prod_move)
                prod_valid_reg <= pk_valid_reg;
            if (out_free)
                out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_ready && tok.valid)
            pk_reg <= tok.peak;
        if (pk_move)
        begin
            prod_reg <= pk_reg * cfg.gain;
            dead_reg <= (pk_reg <= cfg.deadband);
        end
        if (prod_move)
            cur_reg <= cur_next;
    end

    assign out_valid  = out_valid_reg;
    assign current_ma = cur_reg;

endmodule

### design/current_sensor_peak_rms.sv
// ----------------------------------------------------------------------------
// current_sensor_peak_rms
// Moving-average peak detector that reports the scaled windowed peak current in mA.
// ----------------------------------------------------------------------------
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------
//   input     | in_valid / in_ready    | adc_sample
//   output    | out_valid / out_ready  | current_ma
//   config    | cfg_wr_en              | cfg_index, cfg_data
//
// One sample per cycle while in_ready is high: the running sum closes its
// loop through one add and subtract per cycle, and the averaging line shifts
// once per accepted word. After its last sample is accepted, a window result
// passes the stage 1, scaler peak, gain product and output registers.
// Reset clears the averaging line, the sum, the peak and the window count.
// A waiting result stalls input only once the scaler stages are all full.
// ----------------------------------------------------------------------------
module current_sensor_peak_rms
    import csp_pkg::*;
#(
    parameter int AVG_DEPTH = 100,
    parameter int ADC_BITS  = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_BITS-1:0]   adc_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      current_ma
);

    localparam int DEV_W = ADC_BITS + 1;
    localparam int SUM_W = DEV_W + $clog2(AVG_DEPTH);
    localparam int MAG_W = (SUM_W > PEAK_W) ? SUM_W : PEAK_W;
    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(AVG_DEPTH);

    // configuration registers
    logic [ADC_BITS-1:0] zero_offset_reg;
    logic [WIN_W-1:0]    window_reg;
    csp_scale_cfg_t      scale_cfg_reg;

    // stage 1: sample after the ring update
    logic                    s1_valid_reg;
    logic signed [DEV_W-1:0] s1_dev_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic                    s1_fill_reg;
    logic                    s1_last_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [WIN_W-1:0]        count_reg;
    logic [WIN_W-1:0]        count_inc;
    logic [WIN_W-1:0]        limit;
    logic                    last_now;
    logic [PEAK_W-1:0]       peak_reg;
    logic [PEAK_W-1:0]       peak_next;

    logic signed [DEV_W-1:0] dev;
    logic [DEV_W-1:0]        oldest;
    csp_fill_t               fill;
    logic                    accept;
    logic                    s1_move;
    logic                    tok_ready;
    csp_tok_t                tok;

    logic signed [SUM_W-1:0] smooth;
    logic [SUM_W-1:0]        mag;
    logic [PEAK_W-1:0]       mag_sat;
    logic [PEAK_W-1:0]       peak_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg        <= ADC_BITS'(ZERO_RESET);
            window_reg             <= WINDOW_RESET;
            scale_cfg_reg.deadband <= DEADBAND_RESET;
            scale_cfg_reg.gain     <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ZERO_OFFSET:    zero_offset_reg        <= cfg_data[ADC_BITS-1:0];
                REG_WINDOW_SAMPLES: window_reg             <= cfg_data[WIN_W-1:0];
                REG_DEADBAND_SUM:   scale_cfg_reg.deadband <= cfg_data[PEAK_W-1:0];
                REG_GAIN_Q16:       scale_cfg_reg.gain     <= cfg_data[GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign s1_move  = s1_valid_reg && (!s1_last_reg || tok_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    assign dev = $signed({1'b0, adc_sample}) - $signed({1'b0, zero_offset_reg});

    csp_chain #(.DEPTH(AVG_DEPTH), .W(DEV_W)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .din    (dev),
        .oldest (oldest),
        .fill   (fill)
    );

    always_comb
    begin
        // drop the leaving sample, add the new one
        sum_next = sum_reg
                 - $signed({{(SUM_W-DEV_W){oldest[DEV_W-1]}}, oldest})
                 + $signed({{(SUM_W-DEV_W){dev[DEV_W-1]}}, dev});
        count_inc = count_reg + 1'b1;
        limit     = (window_reg == '0) ? WIN_W'(1) : window_reg;
        last_now  = (count_inc >= limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            peak_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                sum_reg   <= sum_next;
                count_reg <= last_now ? '0 : count_inc;
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_move)
                peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dev_reg  <= dev;
            s1_sum_reg  <= sum_next;
            s1_fill_reg <= fill.filled || fill.fill_next;
            s1_last_reg <= last_now;
        end
    end

    // peak stage: smoothed magnitude against the held peak
    always_comb
    begin
        smooth  = s1_fill_reg ? s1_sum_reg
                : SUM_W'($signed({{(SUM_W-DEV_W){s1_dev_reg[DEV_W-1]}}, s1_dev_reg})
                         * DEPTH_S);
        mag     = smooth[SUM_W-1] ? SUM_W'(-smooth) : SUM_W'(smooth);
        mag_sat = (MAG_W'(mag) > MAG_W'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(mag);
        peak_hi = (mag_sat > peak_reg) ? mag_sat : peak_reg;
        peak_next = s1_last_reg ? '0 : peak_hi;
    end

    assign tok.valid = s1_valid_reg && s1_last_reg;
    assign tok.peak  = peak_hi;

    csp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (scale_cfg_reg),
        .tok        (tok),
        .tok_ready  (tok_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .current_ma (current_ma)
    );

endmodule

### design/csp_checker.sv
// ----------------------------------------------------------------------------
// csp_port_checker
// Port-level checks of the current meter, bound to the top level.
// ----------------------------------------------------------------------------
module csp_port_checker
    import csp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] current_ma
);

    // a stalled result holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current_ma))
        else $error("stalled result changed");

    // with the output free, nothing upstream may block input
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked while output is free");

    // no result while reset is held
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

endmodule

bind current_sensor_peak_rms csp_port_checker u_csp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .current_ma (current_ma)
);
